/* hdl/rpm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rpm_pkg;

    // Fixed field widths of the sample and result items.
    localparam int SAMPLE_WIDTH  = 16;
    localparam int WINDOW_WIDTH  = 13;
    localparam int RMS_WIDTH     = 16;
    localparam int POWER_WIDTH   = 32;
    // The mean of a square always fits in this many bits.
    localparam int SQRT_IN_WIDTH = 32;

    localparam logic [WINDOW_WIDTH-1:0] WINDOW_RESET = 13'd256;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] voltage_sample;
        logic signed [SAMPLE_WIDTH-1:0] current_sample;
    } in_item_t;

    typedef struct packed {
        logic [RMS_WIDTH-1:0]          voltage_rms;
        logic [RMS_WIDTH-1:0]          current_rms;
        logic signed [POWER_WIDTH-1:0] real_power;
    } out_item_t;

    typedef enum logic {
        UOP_DIV,
        UOP_SQRT
    } unit_op_t;

    typedef struct packed {
        logic     start;
        unit_op_t op;
    } unit_ctl_t;

endpackage

`default_nettype wire

/* hdl/rpm_seq_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Shared bit-serial unit: restoring division of a sum by the sample count,
// or integer square root of a 32-bit mean. One subtract-and-compare per cycle.
module rpm_seq_unit #(
    parameter int SUM_W = 45,
    parameter int CNT_W = 13
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  rpm_pkg::unit_ctl_t    ctl,
    input  wire [SUM_W-1:0]       operand,
    input  wire [CNT_W-1:0]       divisor,
    output logic                  done,
    output logic [SUM_W-1:0]      result
);
    import rpm_pkg::*;

    localparam int RW     = (CNT_W + 1 > RMS_WIDTH + 2) ? CNT_W + 1 : RMS_WIDTH + 2;
    localparam int STEP_W = $clog2(SUM_W + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [STEP_W-1:0]    step_reg;
    unit_op_t             op_reg;
    logic [SUM_W-1:0]     a_reg;
    logic [RW-1:0]        rem_reg;
    logic [RMS_WIDTH-1:0] root_reg;
    logic [CNT_W-1:0]     div_reg;

    logic [RW-1:0]        rem_sh;
    logic [RW-1:0]        trial;
    logic [RW:0]          diff;
    logic                 ge;

    // The single subtractor serves both operations.
    always_comb
    begin
        if (op_reg == UOP_DIV)
        begin
            rem_sh = {rem_reg[RW-2:0], a_reg[SUM_W-1]};
            trial  = RW'(div_reg);
        end
        else
        begin
            rem_sh = {rem_reg[RW-3:0], a_reg[SUM_W-1 -: 2]};
            trial  = RW'({root_reg, 2'b01});
        end
        diff = {1'b0, rem_sh} - {1'b0, trial};
        ge   = ~diff[RW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= (ctl.op == UOP_DIV) ? STEP_W'(SUM_W) : STEP_W'(RMS_WIDTH);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            op_reg   <= ctl.op;
            div_reg  <= divisor;
            rem_reg  <= '0;
            root_reg <= '0;
            if (ctl.op == UOP_DIV)
                a_reg <= operand;
            else
                a_reg <= {operand[SQRT_IN_WIDTH-1:0], {(SUM_W-SQRT_IN_WIDTH){1'b0}}};
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[RW-1:0] : rem_sh;
            if (op_reg == UOP_DIV)
                a_reg <= {a_reg[SUM_W-2:0], ge};
            else
            begin
                a_reg    <= {a_reg[SUM_W-3:0], 2'b00};
                root_reg <= {root_reg[RMS_WIDTH-2:0], ge};
            end
        end
    end

    assign done   = done_reg;
    assign result = (op_reg == UOP_DIV) ? a_reg : SUM_W'(root_reg);

endmodule

`default_nettype wire

/* hdl/rms_and_real_power_meter.sv */
`timescale 1ns / 1ps
`default_nettype none

// An item that does not close the window steps through ST_MUL_V, ST_MUL_C, ST_MUL_P, ST_ACC
// and ST_CHECK, and in_ready returns then; an item that closes the window then runs three
// divides and two square roots on the shared bit-serial unit; SUM_W = 32+clog2(MAX_WINDOW+1).
// No new item is taken until the last is done; one 16x16 multiplier is used three times.
// Reset (rst_n, asynchronous, active low) clears the sums, the count and the output valid,
// and sets the window length to 256.
module rms_and_real_power_meter #(
    parameter int MAX_WINDOW = 4096
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  rpm_pkg::in_item_t                   in_data,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output rpm_pkg::out_item_t                  out_data,
    input  wire                                 cfg_wr_en,
    input  wire [rpm_pkg::WINDOW_WIDTH-1:0]     cfg_wr_data
);
    import rpm_pkg::*;

    // The count never exceeds MAX_WINDOW; the sums hold MAX_WINDOW products exactly.
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = 2 * SAMPLE_WIDTH + CNT_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_V,
        ST_MUL_C,
        ST_MUL_P,
        ST_ACC,
        ST_CHECK,
        ST_DIV_V,
        ST_SQRT_V,
        ST_DIV_C,
        ST_SQRT_C,
        ST_DIV_P,
        ST_FINISH
    } state_t;

    state_t                          state_reg, state_next;
    logic [WINDOW_WIDTH-1:0]         window_reg, window_next;
    logic signed [SAMPLE_WIDTH-1:0]  v_reg, v_next;
    logic signed [SAMPLE_WIDTH-1:0]  c_reg, c_next;
    logic signed [2*SAMPLE_WIDTH-1:0] prod_reg, prod_next;
    logic [SUM_W-1:0]                vsq_reg, vsq_next;
    logic [SUM_W-1:0]                csq_reg, csq_next;
    logic [SUM_W-1:0]                psum_reg, psum_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    unit_ctl_t                       ctl_reg, ctl_next;
    logic [SUM_W-1:0]                opnd_reg, opnd_next;
    logic                            neg_reg, neg_next;
    logic [RMS_WIDTH-1:0]            vrms_reg, vrms_next;
    logic [RMS_WIDTH-1:0]            crms_reg, crms_next;
    logic signed [POWER_WIDTH-1:0]   pwr_reg, pwr_next;
    logic                            out_valid_reg, out_valid_next;
    out_item_t                       out_data_reg, out_data_next;

    logic signed [SAMPLE_WIDTH-1:0]   mul_a;
    logic signed [SAMPLE_WIDTH-1:0]   mul_b;
    logic signed [2*SAMPLE_WIDTH-1:0] product;
    logic [SUM_W-1:0]                 acc_base;
    logic [SUM_W-1:0]                 acc_sum;
    logic [31:0]                      win32;
    logic [31:0]                      eff32;
    logic                             unit_done;
    logic [SUM_W-1:0]                 unit_result;
    logic [SUM_W-1:0]                 quotient;

    rpm_seq_unit #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_unit (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl_reg),
        .operand (opnd_reg),
        .divisor (count_reg),
        .done    (unit_done),
        .result  (unit_result)
    );

    // One multiplier forms v*v, c*c and v*c in turn; its product is registered
    // and added into the matching sum by a single accumulator adder in the next cycle.
    always_comb
    begin
        mul_a   = (state_reg == ST_MUL_C) ? c_reg : v_reg;
        mul_b   = (state_reg == ST_MUL_V) ? v_reg : c_reg;
        product = mul_a * mul_b;

        case (state_reg)
            ST_MUL_C: acc_base = vsq_reg;
            ST_MUL_P: acc_base = csq_reg;
            default:  acc_base = psum_reg;
        endcase
        acc_sum = acc_base + {{(SUM_W-2*SAMPLE_WIDTH){prod_reg[2*SAMPLE_WIDTH-1]}}, prod_reg};

        // A window of zero acts as one, and a window beyond MAX_WINDOW is clamped.
        win32 = 32'(window_reg);
        if (win32 == 32'd0)
            eff32 = 32'd1;
        else if (win32 > 32'(MAX_WINDOW))
            eff32 = 32'(MAX_WINDOW);
        else
            eff32 = win32;

        // Power is divided as a magnitude, then the sign is put back (truncation toward zero).
        quotient = neg_reg ? (SUM_W'(0) - unit_result) : unit_result;
    end

    always_comb
    begin
        state_next     = state_reg;
        window_next    = window_reg;
        v_next         = v_reg;
        c_next         = c_reg;
        prod_next      = prod_reg;
        vsq_next       = vsq_reg;
        csq_next       = csq_reg;
        psum_next      = psum_reg;
        count_next     = count_reg;
        ctl_next       = '{start: 1'b0, op: ctl_reg.op};
        opnd_next      = opnd_reg;
        neg_next       = neg_reg;
        vrms_next      = vrms_reg;
        crms_next      = crms_reg;
        pwr_next       = pwr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        if (cfg_wr_en)
            window_next = cfg_wr_data;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    v_next     = in_data.voltage_sample;
                    c_next     = in_data.current_sample;
                    state_next = ST_MUL_V;
                end
            end
            ST_MUL_V:
            begin
                prod_next  = product;
                state_next = ST_MUL_C;
            end
            ST_MUL_C:
            begin
                vsq_next   = acc_sum;
                prod_next  = product;
                state_next = ST_MUL_P;
            end
            ST_MUL_P:
            begin
                csq_next   = acc_sum;
                prod_next  = product;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                psum_next  = acc_sum;
                count_next = count_reg + CNT_W'(1);
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                // The window closes once the count reaches the effective length, also when
                // a shorter length was written while the count was already past it.
                if (32'(count_reg) >= eff32)
                begin
                    opnd_next  = vsq_reg;
                    ctl_next   = '{start: 1'b1, op: UOP_DIV};
                    state_next = ST_DIV_V;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_DIV_V:
            begin
                if (unit_done)
                begin
                    opnd_next  = SUM_W'(unit_result[SQRT_IN_WIDTH-1:0]);
                    ctl_next   = '{start: 1'b1, op: UOP_SQRT};
                    state_next = ST_SQRT_V;
                end
            end
            ST_SQRT_V:
            begin
                if (unit_done)
                begin
                    vrms_next  = unit_result[RMS_WIDTH-1:0];
                    opnd_next  = csq_reg;
                    ctl_next   = '{start: 1'b1, op: UOP_DIV};
                    state_next = ST_DIV_C;
                end
            end
            ST_DIV_C:
            begin
                if (unit_done)
                begin
                    opnd_next  = SUM_W'(unit_result[SQRT_IN_WIDTH-1:0]);
                    ctl_next   = '{start: 1'b1, op: UOP_SQRT};
                    state_next = ST_SQRT_C;
                end
            end
            ST_SQRT_C:
            begin
                if (unit_done)
                begin
                    crms_next  = unit_result[RMS_WIDTH-1:0];
                    neg_next   = psum_reg[SUM_W-1];
                    opnd_next  = psum_reg[SUM_W-1] ? (SUM_W'(0) - psum_reg) : psum_reg;
                    ctl_next   = '{start: 1'b1, op: UOP_DIV};
                    state_next = ST_DIV_P;
                end
            end
            ST_DIV_P:
            begin
                if (unit_done)
                begin
                    pwr_next   = quotient[POWER_WIDTH-1:0];
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // Wait here only while an earlier result item is still untaken.
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next.voltage_rms = vrms_reg;
                    out_data_next.current_rms = crms_reg;
                    out_data_next.real_power  = pwr_reg;
                    out_valid_next = 1'b1;
                    vsq_next       = '0;
                    csq_next       = '0;
                    psum_next      = '0;
                    count_next     = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            window_reg    <= WINDOW_RESET;
            v_reg         <= '0;
            c_reg         <= '0;
            prod_reg      <= '0;
            vsq_reg       <= '0;
            csq_reg       <= '0;
            psum_reg      <= '0;
            count_reg     <= '0;
            ctl_reg       <= '{start: 1'b0, op: UOP_DIV};
            opnd_reg      <= '0;
            neg_reg       <= 1'b0;
            vrms_reg      <= '0;
            crms_reg      <= '0;
            pwr_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            window_reg    <= window_next;
            v_reg         <= v_next;
            c_reg         <= c_next;
            prod_reg      <= prod_next;
            vsq_reg       <= vsq_next;
            csq_reg       <= csq_next;
            psum_reg      <= psum_next;
            count_reg     <= count_next;
            ctl_reg       <= ctl_next;
            opnd_reg      <= opnd_next;
            neg_reg       <= neg_next;
            vrms_reg      <= vrms_next;
            crms_reg      <= crms_next;
            pwr_reg       <= pwr_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    // The output register lets a new item enter while a result item waits.
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire
